// File: rtl/mcd_pkg.sv
// Shared types and constants for the Morse code decoder.
// Used by morse_code_decoder_unit and mcd_checker; no dependencies.
package mcd_pkg;

    localparam int MAX_CODE_LEN = 9;
    localparam int ADDR_W       = MAX_CODE_LEN + 1;
    localparam int DEPTH        = 1 << ADDR_W;
    localparam int LEN_W        = $clog2(MAX_CODE_LEN + 1);
    localparam int PAT_W        = 9;
    localparam int PEXT_W       = (MAX_CODE_LEN > PAT_W) ? MAX_CODE_LEN : PAT_W;
    localparam int CLEN_W       = 4;
    localparam int CHAR_W       = 8;

    localparam int SYM_LO     = 0;
    localparam int PAT_LO     = SYM_LO + CHAR_W;
    localparam int LEN_LO     = PAT_LO + PAT_W;
    localparam int LET_LO     = LEN_LO + CLEN_W;
    localparam int IN_TDATA_W = 32;

    localparam logic [CHAR_W-1:0] SYM_DOT     = 8'h2E;
    localparam logic [CHAR_W-1:0] SYM_DASH    = 8'h2D;
    localparam logic [CHAR_W-1:0] SYM_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] SYM_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] SYM_NEWLINE = 8'h0A;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [CHAR_W-1:0] t_char;

    typedef struct packed {
        logic  valid;
        t_char letter;
    } t_entry;

    typedef enum logic [1:0] {
        KIND_CHAR   = 2'd0,
        KIND_LOADED = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE     = 3'd0,
        OP_LOAD     = 3'd1,
        OP_LOAD_BAD = 3'd2,
        OP_SLASH    = 3'd3,
        OP_END      = 3'd4,
        OP_END_NL   = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'b01,
        ST_RUN   = 2'b10
    } t_state;

endpackage

// File: rtl/morse_code_decoder_unit.sv
// Morse code decoder top level: dot/dash trie table, path tracking, result sequencing.
// Depends on mcd_pkg.
//
// Usage:
//   Input beats carry tuser = action (0 decode, 1 load) and tdata = symbol,
//   code_pattern, code_length, letter. Output beats carry tdata = character,
//   tuser = kind (char, loaded, rejected) and tlast on the final result of an item.
//   A load stores a letter at the trie node of its code, or rejects a duplicate or
//   overlong code. Decode beats walk the path with dots and dashes; a space or
//   newline looks up the node and emits its letter if one is stored on a valid
//   path, a slash emits a space, a newline also emits a space and a newline.
//   Pipeline: an accepted item waits in the lookup stage, its results in the output
//   register. Throughput: one input beat per cycle while items yield at most one
//   result and the output is ready; the output port moves one result per cycle, so
//   the result count of each item sets the pace.
//   Reset: a clearing pass writes every one of the 1024 table entries, one per
//   cycle; o_s_tready stays low until the last entry is written.
//   Stall: a held output keeps its result; one more item is taken into the lookup
//   stage, then o_s_tready drops until the output frees up.
module morse_code_decoder_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // symbol[7:0], code_pattern[16:8], code_length[20:17], letter[28:21], zero[31:29]
    input  logic [mcd_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // action[0]
    input  logic                           i_s_tuser,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // out_char[7:0]
    output logic [mcd_pkg::CHAR_W-1:0]     o_m_tdata,
    // kind[1:0]
    output logic [1:0]                     o_m_tuser,
    output logic                           o_m_tlast
);

    mcd_pkg::t_state r_state, n_state;
    mcd_pkg::t_addr  r_clr_addr;

    mcd_pkg::t_entry r_table [mcd_pkg::DEPTH];
    mcd_pkg::t_entry r_rd_data;
    logic            r_fwd_hit;
    mcd_pkg::t_char  r_fwd_letter;

    mcd_pkg::t_addr  r_path_index;
    mcd_pkg::t_len   r_path_length;
    logic            r_path_invalid;

    logic            r_s1_valid;
    mcd_pkg::t_op    r_s1_op;
    mcd_pkg::t_addr  r_s1_addr;
    mcd_pkg::t_char  r_s1_letter;
    logic            r_s1_invalid;

    logic            r_og_valid;
    mcd_pkg::t_kind  r_og_kind;
    mcd_pkg::t_char  r_og_chars [3];
    logic [1:0]      r_og_cnt;
    logic [1:0]      r_og_ptr;

    logic                        in_beat, out_beat, og_last, og_free, s1_fire;
    logic                        is_load;
    mcd_pkg::t_char              sym, let_in;
    logic [mcd_pkg::PAT_W-1:0]   pat;
    logic [mcd_pkg::CLEN_W-1:0]  clen;
    logic [mcd_pkg::PEXT_W-1:0]  pat_ext;
    logic [mcd_pkg::MAX_CODE_LEN-1:0] pat_rev;
    mcd_pkg::t_addr              ld_seed, ld_shift, ld_addr, rd_addr;
    logic                        ld_long;
    mcd_pkg::t_op                op_in;

    mcd_pkg::t_entry             ent;
    logic                        hit, s1_wr;
    mcd_pkg::t_kind              res_kind;
    mcd_pkg::t_char              res_c0, res_c1, res_c2;
    logic [1:0]                  res_cnt;

    logic                        wr_en;
    mcd_pkg::t_addr              wr_addr;
    mcd_pkg::t_entry             wr_data;

    assign sym    = i_s_tdata[mcd_pkg::SYM_LO +: mcd_pkg::CHAR_W];
    assign pat    = i_s_tdata[mcd_pkg::PAT_LO +: mcd_pkg::PAT_W];
    assign clen   = i_s_tdata[mcd_pkg::LEN_LO +: mcd_pkg::CLEN_W];
    assign let_in = i_s_tdata[mcd_pkg::LET_LO +: mcd_pkg::CHAR_W];
    assign is_load = i_s_tuser;

    // Build the heap index of a load code: root bit, then steps from first to last
    always_comb begin
        pat_ext = mcd_pkg::PEXT_W'(pat);
        for (int i = 0; i < mcd_pkg::MAX_CODE_LEN; i++) begin
            pat_rev[mcd_pkg::MAX_CODE_LEN-1-i] = pat_ext[i];
        end
        ld_long  = (int'(clen) > mcd_pkg::MAX_CODE_LEN);
        ld_seed  = {1'b1, pat_rev};
        ld_shift = mcd_pkg::t_addr'(mcd_pkg::MAX_CODE_LEN) - mcd_pkg::t_addr'(clen);
        ld_addr  = ld_seed >> ld_shift;
    end

    always_comb begin
        op_in = mcd_pkg::OP_NONE;
        if (is_load) begin
            op_in = ld_long ? mcd_pkg::OP_LOAD_BAD : mcd_pkg::OP_LOAD;
        end else if (sym == mcd_pkg::SYM_SLASH) begin
            op_in = mcd_pkg::OP_SLASH;
        end else if (sym == mcd_pkg::SYM_SPACE) begin
            op_in = mcd_pkg::OP_END;
        end else if (sym == mcd_pkg::SYM_NEWLINE) begin
            op_in = mcd_pkg::OP_END_NL;
        end
    end

    assign rd_addr = is_load ? ld_addr : r_path_index;

    assign og_last  = (r_og_ptr == r_og_cnt - 2'd1);
    assign out_beat = r_og_valid && i_m_tready;
    assign og_free  = !r_og_valid || (i_m_tready && og_last);
    assign s1_fire  = r_s1_valid && og_free;
    assign o_s_tready = (r_state == mcd_pkg::ST_RUN) && (!r_s1_valid || og_free);
    assign in_beat  = i_s_tvalid && o_s_tready;

    // Lookup stage: evaluate the table entry against the held item
    always_comb begin
        ent      = r_fwd_hit ? mcd_pkg::t_entry'{valid: 1'b1, letter: r_fwd_letter}
                             : r_rd_data;
        hit      = !r_s1_invalid && ent.valid;
        s1_wr    = 1'b0;
        res_kind = mcd_pkg::KIND_CHAR;
        res_c0   = r_s1_letter;
        res_c1   = mcd_pkg::SYM_SPACE;
        res_c2   = mcd_pkg::SYM_NEWLINE;
        res_cnt  = 2'd0;
        case (r_s1_op)
            mcd_pkg::OP_LOAD: begin
                res_kind = ent.valid ? mcd_pkg::KIND_REJECT : mcd_pkg::KIND_LOADED;
                s1_wr    = !ent.valid;
                res_cnt  = 2'd1;
            end
            mcd_pkg::OP_LOAD_BAD: begin
                res_kind = mcd_pkg::KIND_REJECT;
                res_cnt  = 2'd1;
            end
            mcd_pkg::OP_SLASH: begin
                res_c0  = mcd_pkg::SYM_SPACE;
                res_cnt = 2'd1;
            end
            mcd_pkg::OP_END, mcd_pkg::OP_END_NL: begin
                res_c0  = hit ? ent.letter : mcd_pkg::SYM_SPACE;
                res_c1  = hit ? mcd_pkg::SYM_SPACE : mcd_pkg::SYM_NEWLINE;
                res_cnt = {1'b0, hit} + ((r_s1_op == mcd_pkg::OP_END_NL) ? 2'd2 : 2'd0);
            end
            default: begin
                res_cnt = 2'd0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mcd_pkg::ST_CLEAR: begin
                if (r_clr_addr == mcd_pkg::t_addr'(mcd_pkg::DEPTH - 1)) begin
                    n_state = mcd_pkg::ST_RUN;
                end
            end
            mcd_pkg::ST_RUN: begin
                n_state = mcd_pkg::ST_RUN;
            end
            default: begin
                n_state = mcd_pkg::ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        if (r_state == mcd_pkg::ST_CLEAR) begin
            wr_en   = 1'b1;
            wr_addr = r_clr_addr;
            wr_data = '0;
        end else begin
            wr_en   = s1_fire && s1_wr;
            wr_addr = r_s1_addr;
            wr_data = '{valid: 1'b1, letter: r_s1_letter};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_table[wr_addr] <= wr_data;
        end
        if (in_beat) begin
            r_rd_data <= r_table[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= mcd_pkg::ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == mcd_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Path tracking over decode beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_index   <= mcd_pkg::t_addr'(1);
            r_path_length  <= '0;
            r_path_invalid <= 1'b0;
        end else if (in_beat && !is_load) begin
            if (sym == mcd_pkg::SYM_DOT || sym == mcd_pkg::SYM_DASH) begin
                if (r_path_length >= mcd_pkg::t_len'(mcd_pkg::MAX_CODE_LEN)) begin
                    r_path_invalid <= 1'b1;
                end else begin
                    r_path_index  <= {r_path_index[mcd_pkg::ADDR_W-2:0],
                                      (sym == mcd_pkg::SYM_DASH)};
                    r_path_length <= r_path_length + 1'b1;
                end
            end else if (sym == mcd_pkg::SYM_SPACE || sym == mcd_pkg::SYM_NEWLINE) begin
                r_path_index   <= mcd_pkg::t_addr'(1);
                r_path_length  <= '0;
                r_path_invalid <= 1'b0;
            end else if (sym != mcd_pkg::SYM_SLASH) begin
                r_path_invalid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_beat) begin
            r_s1_valid <= 1'b1;
        end else if (s1_fire) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Hold item payload; forward a write landing on the address being read
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_s1_op      <= op_in;
            r_s1_addr    <= rd_addr;
            r_s1_letter  <= let_in;
            r_s1_invalid <= r_path_invalid;
            r_fwd_hit    <= s1_fire && s1_wr && (r_s1_addr == rd_addr);
            r_fwd_letter <= r_s1_letter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_og_valid <= 1'b0;
            r_og_ptr   <= '0;
        end else if (s1_fire) begin
            r_og_valid <= (res_cnt != 2'd0);
            r_og_ptr   <= '0;
        end else if (out_beat) begin
            if (og_last) begin
                r_og_valid <= 1'b0;
            end else begin
                r_og_ptr <= r_og_ptr + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire) begin
            r_og_kind     <= res_kind;
            r_og_cnt      <= res_cnt;
            r_og_chars[0] <= res_c0;
            r_og_chars[1] <= res_c1;
            r_og_chars[2] <= res_c2;
        end
    end

    assign o_m_tvalid = r_og_valid;
    assign o_m_tdata  = r_og_chars[r_og_ptr];
    assign o_m_tuser  = r_og_kind;
    assign o_m_tlast  = og_last;

endmodule

// File: rtl/mcd_checker.sv
// Port-level checks for morse_code_decoder_unit, attached with a bind.
// Depends on mcd_pkg.
module mcd_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [mcd_pkg::CHAR_W-1:0]     o_m_tdata,
    input logic [1:0]                     o_m_tuser,
    input logic                           o_m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("stalled output beat changed");

    a_clear_blocks: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input taken during table clear");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == mcd_pkg::KIND_CHAR || o_m_tuser == mcd_pkg::KIND_LOADED
            || o_m_tuser == mcd_pkg::KIND_REJECT))
        else $error("bad result kind");

    a_load_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser != mcd_pkg::KIND_CHAR |-> o_m_tlast)
        else $error("load result not final");

    a_no_early_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result after reset");

endmodule

bind morse_code_decoder_unit mcd_checker u_mcd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// File: tb/morse_code_decoder_unit_test.sv
`timescale 1ns / 1ps
// Testbench for morse_code_decoder_unit: dictionary loads and Morse symbol streams
// checked beat by beat against an in-bench trie decoder. Depends on mcd_pkg and the RTL.
module morse_code_decoder_unit_test;
    import mcd_pkg::*;

    localparam int   CLK_PERIOD  = 12;
    localparam int   RESET_CYC   = 8;
    localparam int   MAX_GAP     = 12;
    localparam int   TAIL_CYCLES = 8;
    localparam int   CYCLE_LIMIT = 200000;
    localparam int   PRINT_CAP   = 40;
    localparam logic ACT_DECODE  = 1'b0;
    localparam logic ACT_LOAD    = 1'b1;
    localparam t_char SYM_BAD    = 8'hFF;

    typedef struct packed {
        t_kind kind;
        t_char ch;
        logic  last;
    } out_beat_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_TDATA_W-1:0] i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [CHAR_W-1:0]     o_m_tdata;
    logic [1:0]            o_m_tuser;
    logic                  o_m_tlast;

    out_beat_t decoded_q[$];
    bit        node_full[DEPTH];
    t_char     node_letter[DEPTH];
    t_addr     cur_node;
    int        cur_steps;
    bit        cur_broken;

    int err_count    = 0;
    int cycle_count  = 0;
    int gap_max      = MAX_GAP;
    int out_gap_left = 0;
    int hold_req     = 0;

    morse_code_decoder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("morse_code_decoder_unit verification failed");
                $finish;
            end
        end
    end

    task automatic report_mismatch(input string msg);
        if (err_count < PRINT_CAP) begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        err_count++;
    endtask

    // One input item through the trie decoder; queue the beats it yields.
    task automatic trie_step(input logic act, input t_char sym,
                             input logic [PAT_W-1:0] pat, input logic [CLEN_W-1:0] len,
                             input t_char ltr);
        out_beat_t beats[$];
        t_addr     idx;
        if (act == ACT_LOAD) begin
            if (len > MAX_CODE_LEN) begin
                beats.push_back('{KIND_REJECT, ltr, 1'b0});
            end else begin
                idx = t_addr'(1);
                for (int i = 0; i < len; i++) begin
                    idx = {idx[ADDR_W-2:0], pat[i]};
                end
                if (node_full[idx]) begin
                    beats.push_back('{KIND_REJECT, ltr, 1'b0});
                end else begin
                    node_full[idx]   = 1'b1;
                    node_letter[idx] = ltr;
                    beats.push_back('{KIND_LOADED, ltr, 1'b0});
                end
            end
        end else if (sym == SYM_DOT || sym == SYM_DASH) begin
            if (cur_steps >= MAX_CODE_LEN) begin
                cur_broken = 1'b1;
            end else begin
                cur_node = {cur_node[ADDR_W-2:0], sym == SYM_DASH};
                cur_steps++;
            end
        end else if (sym == SYM_SLASH) begin
            beats.push_back('{KIND_CHAR, SYM_SPACE, 1'b0});
        end else if (sym == SYM_SPACE || sym == SYM_NEWLINE) begin
            if (!cur_broken && node_full[cur_node]) begin
                beats.push_back('{KIND_CHAR, node_letter[cur_node], 1'b0});
            end
            cur_node   = t_addr'(1);
            cur_steps  = 0;
            cur_broken = 1'b0;
            if (sym == SYM_NEWLINE) begin
                beats.push_back('{KIND_CHAR, SYM_SPACE, 1'b0});
                beats.push_back('{KIND_CHAR, SYM_NEWLINE, 1'b0});
            end
        end else begin
            cur_broken = 1'b1;
        end
        if (beats.size() > 0) begin
            beats[beats.size() - 1].last = 1'b1;
        end
        foreach (beats[k]) begin
            decoded_q.push_back(beats[k]);
        end
    endtask

    task automatic send_beat(input logic act, input t_char sym,
                             input logic [PAT_W-1:0] pat, input logic [CLEN_W-1:0] len,
                             input t_char ltr);
        int gap;
        gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= act;
        i_s_tdata  <= {{(IN_TDATA_W - LET_LO - CHAR_W){1'b0}}, ltr, len, pat, sym};
        do @(posedge i_clk); while (!o_s_tready);
        trie_step(act, sym, pat, len, ltr);
    endtask

    task automatic send_decode(input t_char sym);
        send_beat(ACT_DECODE, sym, PAT_W'($urandom), CLEN_W'($urandom), CHAR_W'($urandom));
    endtask

    task automatic send_load(input logic [CLEN_W-1:0] len, input logic [PAT_W-1:0] pat,
                             input t_char ltr);
        send_beat(ACT_LOAD, CHAR_W'($urandom), pat, len, ltr);
    endtask

    // Drop valid and hold until every queued beat has arrived.
    task automatic drain_results;
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // Receiver: random gap per beat, plus a long hold on request.
    initial begin
        int hold_left;
        hold_left  = 0;
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (out_gap_left > 0) begin
                out_gap_left--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        out_beat_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (decoded_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat char=%02h kind=%0d last=%0b",
                                          o_m_tdata, o_m_tuser, o_m_tlast));
            end else begin
                want = decoded_q.pop_front();
                if (o_m_tuser !== want.kind) begin
                    report_mismatch($sformatf("kind %0d, want %0d", o_m_tuser, want.kind));
                end
                if (o_m_tdata !== want.ch) begin
                    report_mismatch($sformatf("char %02h, want %02h", o_m_tdata, want.ch));
                end
                if (o_m_tlast !== want.last) begin
                    report_mismatch($sformatf("last %0b, want %0b", o_m_tlast, want.last));
                end
            end
            out_gap_left = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
        end
    end

    task automatic test_dictionary_loads;
        send_load(4'd1, 9'h000, "E");
        send_load(4'd1, 9'h1FE, "T");
        send_load(4'd0, 9'h155, 8'h00);
        send_load(4'd1, 9'h000, "X");
        send_load(4'd10, 9'h0AA, "Q");
        send_load(4'd15, 9'h1FF, 8'h80);
        send_load(4'd9, 9'h1FF, 8'hFF);
        send_load(4'd2, 9'h002, "*");
    endtask

    task automatic test_code_lookup;
        send_decode(SYM_DOT);
        send_decode(SYM_DASH);
        send_decode(SYM_SLASH);
        send_decode(SYM_SPACE);
        send_decode(SYM_DASH);
        send_decode(SYM_NEWLINE);
        send_decode(SYM_SPACE);
        send_decode(SYM_BAD);
        send_decode(SYM_SPACE);
        send_decode(SYM_DASH);
        send_decode(SYM_DASH);
        send_decode(SYM_SPACE);
    endtask

    task automatic test_overlong_path;
        repeat (MAX_CODE_LEN + 1) send_decode(SYM_DASH);
        send_decode(SYM_SPACE);
    endtask

    task automatic test_random_stream(input int n_items);
        int    sent;
        int    pick;
        int    steps;
        int    len;
        t_char sym;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(99, 0);
            if (pick < 25) begin
                pick = $urandom_range(9, 0);
                if (pick < 7) len = $urandom_range(4, 1);
                else if (pick < 9) len = $urandom_range(MAX_CODE_LEN, 0);
                else len = $urandom_range(15, MAX_CODE_LEN + 1);
                send_load(CLEN_W'(len), PAT_W'($urandom), CHAR_W'($urandom));
                sent++;
            end else if (pick < 85) begin
                steps = ($urandom_range(3, 0) == 0) ? $urandom_range(MAX_CODE_LEN + 2, 0)
                                                    : $urandom_range(4, 1);
                repeat (steps) begin
                    send_decode($urandom_range(1, 0) ? SYM_DASH : SYM_DOT);
                    sent++;
                end
                pick = $urandom_range(9, 0);
                if (pick < 6) sym = SYM_SPACE;
                else if (pick < 8) sym = SYM_NEWLINE;
                else sym = SYM_SLASH;
                send_decode(sym);
                sent++;
            end else begin
                send_beat(1'($urandom), CHAR_W'($urandom), PAT_W'($urandom),
                          CLEN_W'($urandom), CHAR_W'($urandom));
                sent++;
            end
        end
    endtask

    // Hold the output long enough that the block backs up onto its input.
    task automatic test_output_backpressure;
        drain_results();
        hold_req = 80;
        repeat (24) send_decode(SYM_SLASH);
        drain_results();
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tuser  = ACT_DECODE;
        i_s_tdata  = '0;
        for (int n = 0; n < DEPTH; n++) begin
            node_full[n]   = 1'b0;
            node_letter[n] = '0;
        end
        cur_node   = t_addr'(1);
        cur_steps  = 0;
        cur_broken = 1'b0;
        repeat (RESET_CYC) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_dictionary_loads();
        test_code_lookup();
        test_overlong_path();
        test_random_stream(150);
        gap_max = 0;
        test_random_stream(80);
        gap_max = MAX_GAP;
        test_output_backpressure();
        test_random_stream(80);
        drain_results();

        if (err_count == 0) begin
            $display("morse_code_decoder_unit verification clean");
        end else begin
            $display("morse_code_decoder_unit verification failed");
        end
        $finish;
    end

endmodule
